[rtl/fds_pkg.sv]
// ----------------------------------------------------------------------------
// fds_pkg: shared types and constants
// Item layouts, field widths and register codes for the frame difference
// detector.
// ----------------------------------------------------------------------------
package fds_pkg;

   localparam int PIXEL_W    = 24;
   localparam int COUNT_W    = 17;
   localparam int THRESH_W   = 7;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [THRESH_W-1:0] PCT          = 7'd100;
   localparam logic [THRESH_W-1:0] THRESH_RESET = 7'd1;

   // register index, taken from paddr[2]
   localparam logic REG_SIMILAR_THRESHOLD = 1'b0;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
      logic       frame_end;
   } fds_req_type;

   typedef struct packed {
      logic [COUNT_W-1:0] diff_count;
      logic [COUNT_W-1:0] compared_count;
      logic               similar;
      logic               keep;
   } fds_rsp_type;

endpackage

[rtl/frame_difference_stable_detector_top.sv]
// ----------------------------------------------------------------------------
// frame_difference_stable_detector_top: frame differencing change detector
// Counts pixels that differ from the stored previous frame and reports,
// per frame, the counts plus similar and keep flags.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake          item
//   req_      in         valid / ready      one pixel (blue, green, red, frame_end)
//   rsp_      out        valid / ready      one frame result
//   csr_      in/out     APB, pready high   similar_threshold at byte 0
//
// One pixel per clock while req_ready stays high. The frame store is one
// RAM whose read and write of the same entry share a cycle (read returns
// the old pixel), so the store port sets the rate at one item per cycle.
// A frame result goes through the compare and decision stages to rsp_.
// Reset clears counters and flags only; the store needs no clearing pass.
// A stalled result holds one tally behind it; req_ready drops only once
// that tally slot and the compare stage are both full.
//
module frame_difference_stable_detector_top #(
   parameter int FRAME_PIXELS = 65536
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  fds_pkg::fds_req_type              req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output fds_pkg::fds_rsp_type              rsp_data,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [fds_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [fds_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [fds_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   localparam int CNT_W = $clog2(FRAME_PIXELS + 1);

   // configuration register
   logic [fds_pkg::THRESH_W-1:0] thresh_ff, thresh_in;
   logic                         csr_write, csr_hit;

   assign csr_pready = 1'b1;
   assign csr_hit    = csr_paddr[2] == fds_pkg::REG_SIMILAR_THRESHOLD;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign thresh_in  = (csr_write && csr_hit) ?
                       csr_pwdata[fds_pkg::THRESH_W-1:0] : thresh_ff;
   assign csr_prdata = csr_hit ? fds_pkg::CSR_DATA_W'(thresh_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= fds_pkg::THRESH_RESET;
      end else begin
         thresh_ff <= thresh_in;
      end
   end

   // compare stage -> decision stage
   logic             tally_valid, hold;
   logic [CNT_W-1:0] tally_diff, tally_n;

   fds_compare #(
      .FRAME_PIXELS (FRAME_PIXELS)
   ) u_compare (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .hold        (hold),
      .tally_valid (tally_valid),
      .tally_diff  (tally_diff),
      .tally_n     (tally_n)
   );

   fds_judge #(
      .CNT_W (CNT_W)
   ) u_judge (
      .clock       (clock),
      .reset       (reset),
      .tally_valid (tally_valid),
      .tally_diff  (tally_diff),
      .tally_n     (tally_n),
      .threshold   (thresh_ff),
      .hold        (hold),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

   // checks
   a_diff_le_compared : assert property (@(posedge clock) disable iff (reset)
      tally_valid |-> tally_diff <= tally_n)
      else $error("difference count exceeds compared count");

   a_keep_needs_similar : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_data.keep || rsp_data.similar))
      else $error("keep set on a dissimilar frame");

   a_no_tally_when_held : assert property (@(posedge clock) disable iff (reset)
      hold |-> !req_ready || !tally_valid)
      else $error("tally issued while decision stage is held");

endmodule

[rtl/fds_ram.sv]
// ----------------------------------------------------------------------------
// fds_ram: generic simple dual-port RAM
// One write port, one read port, registered read (old data on collision).
// ----------------------------------------------------------------------------
module fds_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 65536,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[rtl/fds_compare.sv]
// ----------------------------------------------------------------------------
// fds_compare: frame store access and difference counting
// Reads the stored pixel and writes the new one in the same cycle, then
// compares the registered pair and hands a per-frame tally downstream.
// ----------------------------------------------------------------------------
module fds_compare #(
   parameter int FRAME_PIXELS = 65536,
   localparam int CNT_W  = $clog2(FRAME_PIXELS + 1),
   localparam int ADDR_W = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  fds_pkg::fds_req_type req_data,
   input  logic                 hold,
   output logic                 tally_valid,
   output logic [CNT_W-1:0]     tally_diff,
   output logic [CNT_W-1:0]     tally_n
);

   localparam logic [CNT_W-1:0] FRAME_CNT = CNT_W'(FRAME_PIXELS);

   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] prev_len_ff, prev_len_in;
   logic             have_prev_ff, have_prev_in;
   logic [CNT_W-1:0] diff_ff, diff_in;

   logic                        s1_valid_ff, s1_valid_in;
   logic [fds_pkg::PIXEL_W-1:0] s1_pixel_ff;
   logic                        s1_cmp_ff;
   logic                        s1_last_ff;
   logic                        s1_emit_ff;
   logic [CNT_W-1:0]            s1_n_ff;

   logic                        accept, in_range, cmp0, s1_go, differ;
   logic [CNT_W-1:0]            len_new, n0, diff_sum;
   logic [fds_pkg::PIXEL_W-1:0] pixel, stored;

   assign pixel    = {req_data.red, req_data.green, req_data.blue};
   assign in_range = idx_ff < FRAME_CNT;
   assign len_new  = idx_ff + CNT_W'(in_range);
   assign n0       = (len_new < prev_len_ff) ? len_new : prev_len_ff;
   assign cmp0     = have_prev_ff && in_range && (idx_ff < prev_len_ff);

   assign s1_go     = s1_valid_ff && !hold;
   assign req_ready = !s1_valid_ff || s1_go;
   assign accept    = req_valid && req_ready;

   fds_ram #(
      .WIDTH (fds_pkg::PIXEL_W),
      .DEPTH (FRAME_PIXELS)
   ) u_store (
      .clock (clock),
      .we    (accept && in_range),
      .waddr (idx_ff[ADDR_W-1:0]),
      .wdata (pixel),
      .re    (accept && in_range),
      .raddr (idx_ff[ADDR_W-1:0]),
      .rdata (stored)
   );

   assign differ   = s1_cmp_ff && (stored != s1_pixel_ff);
   assign diff_sum = diff_ff + CNT_W'(differ);

   always_comb begin
      idx_in       = idx_ff;
      prev_len_in  = prev_len_ff;
      have_prev_in = have_prev_ff;
      if (accept) begin
         if (req_data.frame_end) begin
            idx_in       = '0;
            prev_len_in  = len_new;
            have_prev_in = 1'b1;
         end else begin
            idx_in = len_new;
         end
      end
   end

   always_comb begin
      diff_in = diff_ff;
      if (s1_go) begin
         diff_in = s1_last_ff ? '0 : diff_sum;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         prev_len_ff  <= '0;
         have_prev_ff <= 1'b0;
         diff_ff      <= '0;
         s1_valid_ff  <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         prev_len_ff  <= prev_len_in;
         have_prev_ff <= have_prev_in;
         diff_ff      <= diff_in;
         s1_valid_ff  <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff <= pixel;
         s1_cmp_ff   <= cmp0;
         s1_last_ff  <= req_data.frame_end;
         s1_emit_ff  <= have_prev_ff;
         s1_n_ff     <= n0;
      end
   end

   assign tally_valid = s1_go && s1_last_ff && s1_emit_ff;
   assign tally_diff  = diff_sum;
   assign tally_n     = s1_n_ff;

endmodule

[rtl/fds_judge.sv]
// ----------------------------------------------------------------------------
// fds_judge: similarity decision and result register
// Holds one frame tally, tests diff*100 < threshold*compared, tracks the
// armed flag and drives the result channel.
// ----------------------------------------------------------------------------
module fds_judge #(
   parameter int CNT_W = 17
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           tally_valid,
   input  logic [CNT_W-1:0]               tally_diff,
   input  logic [CNT_W-1:0]               tally_n,
   input  logic [fds_pkg::THRESH_W-1:0]   threshold,
   output logic                           hold,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output fds_pkg::fds_rsp_type           rsp_data
);

   localparam int PROD_W = CNT_W + fds_pkg::THRESH_W;

   logic             s2_valid_ff, s2_valid_in;
   logic [CNT_W-1:0] s2_diff_ff;
   logic [CNT_W-1:0] s2_n_ff;
   logic             armed_ff, armed_in;
   logic             rsp_valid_ff, rsp_valid_in;
   fds_pkg::fds_rsp_type rsp_data_ff;

   logic              out_free, s2_go, sim;
   logic [PROD_W-1:0] lhs, rhs;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign hold     = s2_valid_ff && !out_free;
   assign s2_go    = s2_valid_ff && out_free;

   assign lhs = PROD_W'(s2_diff_ff) * PROD_W'(fds_pkg::PCT);
   assign rhs = PROD_W'(threshold) * PROD_W'(s2_n_ff);
   assign sim = lhs < rhs;

   always_comb begin
      s2_valid_in  = hold ? s2_valid_ff : tally_valid;
      armed_in     = s2_go ? !sim : armed_ff;
      rsp_valid_in = rsp_valid_ff;
      if (s2_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         armed_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         armed_ff     <= armed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tally_valid && !hold) begin
         s2_diff_ff <= tally_diff;
         s2_n_ff    <= tally_n;
      end
      if (s2_go) begin
         rsp_data_ff.diff_count     <= fds_pkg::COUNT_W'(s2_diff_ff);
         rsp_data_ff.compared_count <= fds_pkg::COUNT_W'(s2_n_ff);
         rsp_data_ff.similar        <= sim;
         rsp_data_ff.keep           <= sim && armed_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[tb/tb_frame_difference_stable_detector_top.sv]
// ----------------------------------------------------------------------------
// tb_frame_difference_stable_detector_top: self-checking bench for the detector
// Streams pixel frames through the req_ channel, with random gaps on both
// sides. A shadow copy of the previous frame predicts each per-frame result,
// and every rsp_ item is checked field by field against it.
// ----------------------------------------------------------------------------
module tb_frame_difference_stable_detector_top;

   localparam int unsigned FRAME_PIXELS  = 65536;
   localparam int unsigned RANDOM_ITEMS  = 300;
   localparam int unsigned LIMIT_CYCLES  = 100_000;
   // settle time after a drain, with margin on top
   localparam int unsigned SETTLE_CYCLES = 8;

   localparam logic [fds_pkg::CSR_ADDR_W-1:0] ADDR_THRESHOLD = 3'd0;
   localparam logic [fds_pkg::CSR_ADDR_W-1:0] ADDR_UNMAPPED  = 3'd4;

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           req_valid;
   logic                           req_ready;
   fds_pkg::fds_req_type           req_data;
   logic                           rsp_valid;
   logic                           rsp_ready;
   fds_pkg::fds_rsp_type           rsp_data;
   logic                           csr_psel;
   logic                           csr_penable;
   logic                           csr_pwrite;
   logic [fds_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [fds_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [fds_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   // shared bench state
   bit                             idling = 1'b1;   // random gaps on both channels
   int unsigned                    errors = 0;
   int unsigned                    cycle_count = 0;

   // frame model: shadow of the previous frame plus the running tallies
   bit   [fds_pkg::PIXEL_W-1:0]    shadow_frame [FRAME_PIXELS];
   int unsigned                    pix_pos = 0;
   int unsigned                    frame_diffs = 0;
   int unsigned                    prev_len = 0;
   bit                             have_prev = 1'b0;
   bit                             keep_armed = 1'b1;
   logic [fds_pkg::THRESH_W-1:0]   threshold = fds_pkg::THRESH_RESET;
   fds_pkg::fds_rsp_type           expected_frames [$];
   fds_pkg::fds_rsp_type           want;

   always #5 clock = ~clock;

   frame_difference_stable_detector_top #(
      .FRAME_PIXELS(FRAME_PIXELS)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   // -------------------------------------------------------------------------
   // Frame model. Called once per accepted pixel; on the last pixel of every
   // frame after the first it queues the expected frame result.
   // -------------------------------------------------------------------------
   function automatic void account_pixel(input fds_pkg::fds_req_type px);
      logic [fds_pkg::PIXEL_W-1:0] rgb;
      int unsigned                 n;
      longint unsigned             lhs;
      longint unsigned             rhs;
      bit                          sim;
      fds_pkg::fds_rsp_type        r;
      rgb = {px.red, px.green, px.blue};
      // pixels past the store size are neither stored nor compared
      if (pix_pos < FRAME_PIXELS) begin
         if (have_prev && pix_pos < prev_len && shadow_frame[pix_pos] != rgb) begin
            frame_diffs++;
         end
         shadow_frame[pix_pos] = rgb;
         pix_pos++;
      end
      if (px.frame_end) begin
         if (have_prev) begin
            n = (pix_pos < prev_len) ? pix_pos : prev_len;
            // percent test without division: diff*100 < threshold*compared
            lhs = frame_diffs;
            lhs = lhs * fds_pkg::PCT;
            rhs = threshold;
            rhs = rhs * n;
            sim = (lhs < rhs);
            r.diff_count     = frame_diffs[fds_pkg::COUNT_W-1:0];
            r.compared_count = n[fds_pkg::COUNT_W-1:0];
            r.similar        = sim;
            r.keep           = sim && keep_armed;
            keep_armed       = !sim;
            expected_frames.insert(expected_frames.size(), r);
         end
         prev_len    = pix_pos;
         have_prev   = 1'b1;
         pix_pos     = 0;
         frame_diffs = 0;
      end
   endfunction

   function automatic fds_pkg::fds_req_type mk_pixel(input logic [7:0] red,
                                                     input logic [7:0] green,
                                                     input logic [7:0] blue,
                                                     input bit last);
      fds_pkg::fds_req_type px;
      px.red       = red;
      px.green     = green;
      px.blue      = blue;
      px.frame_end = last;
      return px;
   endfunction

   // -------------------------------------------------------------------------
   // Pixel sender. Entered and left at a falling edge. Valid stays high across
   // back-to-back items; it only drops for a drawn gap or a drain.
   // -------------------------------------------------------------------------
   task automatic send_pixel(input fds_pkg::fds_req_type px);
      int gap;
      gap = idling ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= px;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      account_pixel(px);
      @(negedge clock);
   endtask

   // One frame of len pixels. change_pm: per-mille chance that a pixel differs
   // from the stored one (single bit flip or fully random).
   task automatic send_frame(input int unsigned len, input int unsigned change_pm);
      logic [fds_pkg::PIXEL_W-1:0] rgb;
      for (int unsigned i = 0; i < len; i++) begin
         rgb = (i < FRAME_PIXELS) ? shadow_frame[i] : fds_pkg::PIXEL_W'($urandom);
         if ($urandom_range(0, 999) < change_pm) begin
            if ($urandom_range(0, 1) == 1) begin
               rgb ^= fds_pkg::PIXEL_W'(1) << $urandom_range(0, fds_pkg::PIXEL_W - 1);
            end else begin
               rgb = fds_pkg::PIXEL_W'($urandom);
            end
         end
         send_pixel(mk_pixel(rgb[23:16], rgb[15:8], rgb[7:0], i == len - 1));
      end
   endtask

   // Sender holds off until every queued frame result has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (expected_frames.size() != 0);
   endtask

   // Idle point for register access: drained, plus pipeline latency.
   task automatic quiesce();
      drain_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // APB setup + access; reads are checked against the modeled threshold.
   task automatic csr_access(input bit wr, input logic [fds_pkg::CSR_ADDR_W-1:0] addr,
                             input logic [fds_pkg::CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (wr) begin
         if (addr[2] == fds_pkg::REG_SIMILAR_THRESHOLD) begin
            threshold = data[fds_pkg::THRESH_W-1:0];
         end
      end else if (addr[2] == fds_pkg::REG_SIMILAR_THRESHOLD &&
                   csr_prdata !== fds_pkg::CSR_DATA_W'(threshold)) begin
         $display("%0t: threshold readback expected %0d got %0d", $time,
                  threshold, csr_prdata);
         errors++;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   // Write the threshold (upper bus bits random, must be dropped), read back.
   task automatic program_threshold(input logic [fds_pkg::THRESH_W-1:0] value);
      quiesce();
      csr_access(1'b1, ADDR_THRESHOLD,
                 ($urandom & ~32'h7F) | fds_pkg::CSR_DATA_W'(value));
      csr_access(1'b0, ADDR_THRESHOLD, '0);
   endtask

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Reset threshold, channel extremes, first frame silent, unequal lengths,
   // keep arming across similar / dissimilar frames.
   task automatic test_first_frames();
      csr_access(1'b0, ADDR_THRESHOLD, '0);
      // first frame: fills the store, no result
      send_pixel(mk_pixel(8'h00, 8'h00, 8'h00, 1'b0));
      send_pixel(mk_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0));
      send_pixel(mk_pixel(8'hFF, 8'h00, 8'h00, 1'b0));
      send_pixel(mk_pixel(8'h00, 8'hFF, 8'h00, 1'b0));
      send_pixel(mk_pixel(8'h00, 8'h00, 8'hFF, 1'b1));
      // identical frame: similar and kept
      send_pixel(mk_pixel(8'h00, 8'h00, 8'h00, 1'b0));
      send_pixel(mk_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0));
      send_pixel(mk_pixel(8'hFF, 8'h00, 8'h00, 1'b0));
      send_pixel(mk_pixel(8'h00, 8'hFF, 8'h00, 1'b0));
      send_pixel(mk_pixel(8'h00, 8'h00, 8'hFF, 1'b1));
      // shorter frame, two single-channel changes: dissimilar, rearms keep
      send_pixel(mk_pixel(8'h01, 8'h00, 8'h00, 1'b0));
      send_pixel(mk_pixel(8'hFF, 8'hFF, 8'hFE, 1'b0));
      send_pixel(mk_pixel(8'hFF, 8'h00, 8'h00, 1'b1));
      // longer frame: only the first three compared
      send_pixel(mk_pixel(8'h01, 8'h00, 8'h00, 1'b0));
      send_pixel(mk_pixel(8'hFF, 8'hFF, 8'hFE, 1'b0));
      send_pixel(mk_pixel(8'hFF, 8'h00, 8'h00, 1'b0));
      send_pixel(mk_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0));
      send_pixel(mk_pixel(8'h00, 8'h00, 8'h00, 1'b0));
      send_pixel(mk_pixel(8'h80, 8'h40, 8'h20, 1'b1));
   endtask

   // Threshold extremes incl. out-of-range values, and an unmapped write.
   task automatic test_threshold_settings();
      logic [fds_pkg::THRESH_W-1:0] levels [6];
      levels = '{7'd0, 7'd101, 7'd127, 7'd100, 7'd50, 7'd2};
      foreach (levels[i]) begin
         program_threshold(levels[i]);
         if (i == 3) begin
            // index 1 does not exist; threshold must be untouched
            csr_access(1'b1, ADDR_UNMAPPED, $urandom);
            csr_access(1'b0, ADDR_THRESHOLD, '0);
         end
         repeat (3) send_frame($urandom_range(1, 8), $urandom_range(0, 700));
      end
   endtask

   // Frames sent with no gaps on either side: an all-different frame, a
   // mostly-equal frame of the same length, a longer unchanged frame and a
   // 1-pixel frame.
   task automatic test_gapless_frames();
      quiesce();
      idling = 1'b0;
      send_frame(40, 1000);
      send_frame(40, 50);
      send_frame(48, 0);
      send_frame(1, 0);
      idling = 1'b1;
   endtask

   // Random video: mostly near-copies of the previous frame at varying change
   // rates and lengths, periodic threshold changes, gaps toggled per frame.
   task automatic test_random_video();
      int unsigned sent;
      int unsigned since_cfg;
      int unsigned len;
      int unsigned change_levels [6];
      change_levels = '{0, 20, 100, 300, 600, 1000};
      sent      = 0;
      since_cfg = 0;
      while (sent < RANDOM_ITEMS) begin
         if (since_cfg >= 100) begin
            program_threshold(($urandom_range(0, 3) != 0) ?
                              fds_pkg::THRESH_W'($urandom_range(0, 101)) :
                              fds_pkg::THRESH_W'($urandom_range(0, 127)));
            since_cfg = 0;
         end
         if ($urandom_range(0, 7) == 0) drain_results();
         idling = ($urandom_range(0, 5) != 0);
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
         send_frame(len, change_levels[$urandom_range(0, 5)]);
         sent      += len;
         since_cfg += len;
      end
      idling = 1'b1;
   endtask

   // -------------------------------------------------------------------------
   // Result side: random stalls per item on rsp_ready, checker at the edge.
   // -------------------------------------------------------------------------
   initial begin
      int stall;
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         stall = idling ? $urandom_range(0, 4) : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   task automatic check_field(input string field, input int unsigned exp_val,
                              input int unsigned act_val);
      if (exp_val != act_val) begin
         $display("%0t: %s expected %0d got %0d", $time, field, exp_val, act_val);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_frames.size() == 0) begin
            $display("%0t: frame result expected none got %p", $time, rsp_data);
            errors++;
         end else begin
            want = expected_frames.pop_front();
            check_field("diff_count", want.diff_count, rsp_data.diff_count);
            check_field("compared_count", want.compared_count, rsp_data.compared_count);
            check_field("similar", want.similar, rsp_data.similar);
            check_field("keep", want.keep, rsp_data.keep);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("%0t: timeout, %0d frame results outstanding", $time,
                  expected_frames.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Sequence: reset, directed tests, gapless frames, random video, final drain.
   // -------------------------------------------------------------------------
   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_first_frames();
      test_threshold_settings();
      test_gapless_frames();
      test_random_video();
      quiesce();
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

[frame_difference_stable_detector_top.f]
rtl/fds_pkg.sv
rtl/fds_ram.sv
rtl/fds_compare.sv
rtl/fds_judge.sv
rtl/frame_difference_stable_detector_top.sv
tb/tb_frame_difference_stable_detector_top.sv
